// ----- design/piecewise_cubic_bezier_eval_top_defines.svh -----
// assertion macros shared by the curve evaluator
`ifndef PIECEWISE_CUBIC_BEZIER_EVAL_TOP_DEFINES_SVH
`define PIECEWISE_CUBIC_BEZIER_EVAL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PCBE_ASSERT(lbl, expr) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  (expr)) else $error("pcbe check failed");
`define PCBE_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) (ante) |=> (cons)) else $error("pcbe check failed");
`else
`define PCBE_ASSERT(lbl, expr)
`define PCBE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/pcbe_pkg.sv -----
`default_nettype none
package pcbe_pkg;
  localparam int MAX_POINTS = 64;
  localparam int MAX_SEGS   = (MAX_POINTS - 1) / 3;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SEG_W      = $clog2(MAX_SEGS + 1);
  localparam int FRAC_W     = 17;
  localparam int SUM_W      = 34;
  localparam logic [31:0] ONE_Q16 = 32'd65536;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SETDUR = 2'd2,
    CMD_EVAL   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_IGNORED = 2'd1,
    ST_BAD     = 2'd2,
    ST_CLAMPED = 2'd3
  } status_e;

  // point store port: one write, one read
  typedef struct packed {
    logic             wr_en;
    logic [PT_AW-1:0] wr_addr;
    logic [95:0]      wr_data;
    logic [PT_AW-1:0] rd_addr;
  } pt_req_t;

  // duration store port
  typedef struct packed {
    logic             wr_en;
    logic             clr_en;
    logic [SEG_W-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic [SEG_W-1:0] rd_addr;
  } dur_req_t;

  // first operand slot for each of the six interpolation steps of one axis
  function automatic logic [1:0] lerp_src(input logic [2:0] step);
    logic [1:0] r;
    case (step)
      3'd0: r = 2'd0;
      3'd1: r = 2'd1;
      3'd2: r = 2'd2;
      3'd3: r = 2'd0;
      3'd4: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- design/pcbe_point_mem.sv -----
`default_nettype none
module pcbe_point_mem (
  input  wire              clk_i,
  input  pcbe_pkg::pt_req_t req_i,
  output logic [95:0]      rd_data_o
);
  import pcbe_pkg::*;

  logic [95:0] mem [MAX_POINTS];

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[req_i.rd_addr];
  end
endmodule
`default_nettype wire

// ----- design/pcbe_dur_mem.sv -----
`default_nettype none
module pcbe_dur_mem (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  pcbe_pkg::dur_req_t req_i,
  output logic [31:0]        rd_data_o
);
  import pcbe_pkg::*;

  logic [31:0]         mem [MAX_SEGS];
  logic [MAX_SEGS-1:0] vld_q;
  logic [31:0]         data_q;
  logic                dvld_q;

  // entry data
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    data_q <= mem[req_i.rd_addr];
  end

  // valid bits, invalid entry reads as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      dvld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end else if (req_i.clr_en) begin
        vld_q[req_i.wr_addr] <= 1'b0;
      end
      dvld_q <= vld_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = dvld_q ? data_q : ONE_Q16;
endmodule
`default_nettype wire

// ----- design/pcbe_div.sv -----
`default_nettype none
module pcbe_div (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [31:0] num_i,
  input  wire  [31:0] den_i,
  output logic        done_o,
  output logic [15:0] quot_o
);
  import pcbe_pkg::*;

  logic [32:0] rem_q, rem_sh;
  logic [31:0] den_q;
  logic [4:0]  cnt_q;
  logic        run_q;

  assign rem_sh = {rem_q[31:0], 1'b0};

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'd16;
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_o <= '0;
    end else if (run_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q  <= rem_sh - {1'b0, den_q};
        quot_o <= {quot_o[14:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_o <= {quot_o[14:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ----- design/pcbe_lerp.sv -----
`default_nettype none
module pcbe_lerp (
  input  wire                       clk_i,
  input  wire  signed [31:0]        a_i,
  input  wire  signed [31:0]        b_i,
  input  wire  [pcbe_pkg::FRAC_W-1:0] f_i,
  output logic signed [31:0]        res_o
);
  import pcbe_pkg::*;

  logic signed [49:0] ma_q, mb_q;
  logic signed [50:0] sum;
  logic [FRAC_W-1:0]  g;

  assign g = FRAC_W'(ONE_Q16) - f_i;

  // weighted products
  always_ff @(posedge clk_i) begin
    ma_q <= a_i * $signed({1'b0, g});
    mb_q <= b_i * $signed({1'b0, f_i});
  end

  // round half up, result lies between the endpoints
  assign sum   = 51'(ma_q) + 51'(mb_q) + 51'sd32768;
  assign res_o = sum[47:16];
endmodule
`default_nettype wire

// ----- design/piecewise_cubic_bezier_eval_top.sv -----
// channel   fields                                                      handshake
// command   command_i x/y/z_in_i seg_index_i duration_in_i time_in_i    start / busy
// result    x_out_o y_out_o z_out_o status_o points_held_o              done_o strobe
//
// append, remove and set duration: busy for the decode state only, done_o in the cycle after.
// evaluate: decode, the duration walk one segment at a time (up to 21 segments), the fraction
// divider unless the offset reaches the segment duration, the point reads and the interpolation
// steps through the shared lerp unit (18 steps); done_o in the cycle after.
// reset is asynchronous; durations read as 1.0 right after it.
// done_o is high for one cycle; the receiver cannot stall.
`default_nettype none
`include "piecewise_cubic_bezier_eval_top_defines.svh"
module piecewise_cubic_bezier_eval_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         command_i,
  input  wire  signed [31:0] x_in_i,
  input  wire  signed [31:0] y_in_i,
  input  wire  signed [31:0] z_in_i,
  input  wire  [4:0]         seg_index_i,
  input  wire  [31:0]        duration_in_i,
  input  wire  signed [31:0] time_in_i,
  output logic               done_o,
  output logic signed [31:0] x_out_o,
  output logic signed [31:0] y_out_o,
  output logic signed [31:0] z_out_o,
  output logic [1:0]         status_o,
  output logic [6:0]         points_held_o
);
  import pcbe_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_WALK = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_PRD  = 4'd4;
  localparam logic [3:0] S_LA   = 4'd5;
  localparam logic [3:0] S_LB   = 4'd6;
  localparam logic [3:0] S_PT   = 4'd7;

  logic [3:0]         state_q;
  cmd_e               cmd_q;
  logic signed [31:0] px_q, py_q, pz_q, t_q;
  logic [4:0]         idx_q;
  logic [31:0]        dlen_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [1:0]         rem_q;
  logic [SEG_W-1:0]   segs_q, wi_q;
  logic [SUM_W-1:0]   beg_q;
  logic [PT_AW-1:0]   base_q;
  logic [FRAC_W-1:0]  f_q;
  logic [2:0]         pc_q, sub_q;
  logic [1:0]         axis_q;
  logic signed [31:0] ax_q [3][4];
  logic [1:0]         status_q;
  status_e            st;

  pt_req_t            pt_req;
  dur_req_t           dur_req;
  logic [95:0]        pt_rd;
  logic [31:0]        dur_rd;
  logic               div_start, div_done;
  logic [15:0]        div_q;
  logic signed [31:0] la, lb, lres;
  logic [1:0]         asel;

  // walk helpers
  logic [SUM_W-1:0]   sum, tu;
  logic               more, past;
  logic [31:0]        off;
  logic [PT_AW-1:0]   last_pt;
  logic               can_app, seg_done;

  assign busy          = (state_q != S_IDLE);
  assign points_held_o = cnt_q;
  assign status_o      = status_q;

  assign tu       = SUM_W'(unsigned'(t_q));
  assign sum      = beg_q + SUM_W'(dur_rd);
  assign more     = ((SEG_W+1)'(wi_q) + 1'b1 < (SEG_W+1)'(segs_q)) && (tu > sum);
  assign past     = tu > sum;
  assign off      = t_q - beg_q[31:0];
  assign last_pt  = PT_AW'({segs_q, 1'b0}) + PT_AW'(segs_q);
  assign can_app  = cnt_q < CNT_W'(MAX_POINTS);
  assign seg_done = (cnt_q >= CNT_W'(3)) && (rem_q == 2'd0);
  assign asel     = lerp_src(sub_q);
  assign la       = ax_q[0][asel];
  assign lb       = ax_q[0][asel + 2'd1];

  // memory requests
  always_comb begin
    pt_req         = '0;
    pt_req.wr_en   = (state_q == S_EXEC) && (cmd_q == CMD_APPEND) && can_app;
    pt_req.wr_addr = cnt_q[PT_AW-1:0];
    pt_req.wr_data = {px_q, py_q, pz_q};
    case (state_q)
      S_WALK:  pt_req.rd_addr = last_pt;
      S_PRD:   pt_req.rd_addr = base_q + PT_AW'(pc_q);
      default: pt_req.rd_addr = '0;
    endcase
    dur_req         = '0;
    dur_req.wr_en   = (state_q == S_EXEC) && (cmd_q == CMD_SETDUR) &&
                      ({1'b0, idx_q} < 6'(segs_q)) && (dlen_q != '0);
    dur_req.clr_en  = (state_q == S_EXEC) && (cmd_q == CMD_APPEND) && can_app && seg_done;
    dur_req.wr_addr = (cmd_q == CMD_SETDUR) ? SEG_W'(idx_q) : segs_q;
    dur_req.wr_data = dlen_q;
    dur_req.rd_addr = (state_q == S_WALK) ? wi_q + 1'b1 : '0;
  end

  assign div_start = (state_q == S_WALK) && !more && !past && (off < dur_rd);
  assign st        = (cmd_q == CMD_SETDUR) ? ST_BAD : ST_IGNORED;

  pcbe_point_mem u_pts (.clk_i(clk_i), .req_i(pt_req), .rd_data_o(pt_rd));
  pcbe_dur_mem u_dur (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dur_req), .rd_data_o(dur_rd));
  pcbe_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(off),
    .den_i(dur_rd), .done_o(div_done), .quot_o(div_q)
  );
  pcbe_lerp u_lerp (.clk_i(clk_i), .a_i(la), .b_i(lb), .f_i(f_q), .res_o(lres));

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      segs_q  <= '0;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) state_q <= S_EXEC;
        end
        S_EXEC: begin
          case (cmd_q)
            CMD_APPEND: begin
              if (can_app) begin
                cnt_q <= cnt_q + 1'b1;
                rem_q <= (rem_q == 2'd2) ? 2'd0 : rem_q + 2'd1;
                if (seg_done) segs_q <= segs_q + 1'b1;
              end
              done_o  <= 1'b1;
              state_q <= S_IDLE;
            end
            CMD_REMOVE: begin
              if (cnt_q != '0) begin
                cnt_q <= cnt_q - 1'b1;
                rem_q <= (rem_q == 2'd0) ? 2'd2 : rem_q - 2'd1;
                if (cnt_q >= CNT_W'(4) && rem_q == 2'd1) segs_q <= segs_q - 1'b1;
              end
              done_o  <= 1'b1;
              state_q <= S_IDLE;
            end
            CMD_SETDUR: begin
              done_o  <= 1'b1;
              state_q <= S_IDLE;
            end
            default: begin
              if (segs_q == '0) begin
                if (cnt_q != '0) state_q <= S_PT;
                else begin
                  done_o  <= 1'b1;
                  state_q <= S_IDLE;
                end
              end else if (t_q < 0) state_q <= S_PT;
              else state_q <= S_WALK;
            end
          endcase
        end
        S_WALK: begin
          if (!more) begin
            if (past) state_q <= S_PT;
            else if (off < dur_rd) state_q <= S_DIV;
            else state_q <= S_PRD;
          end
        end
        S_DIV: begin
          if (div_done) state_q <= S_PRD;
        end
        S_PRD: begin
          if (pc_q == 3'd4) state_q <= S_LA;
        end
        S_LA: state_q <= S_LB;
        S_LB: begin
          if (sub_q == 3'd5 && axis_q == 2'd2) begin
            done_o  <= 1'b1;
            state_q <= S_IDLE;
          end else state_q <= S_LA;
        end
        S_PT: begin
          done_o  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q  <= cmd_e'(command_i);
        px_q   <= x_in_i;
        py_q   <= y_in_i;
        pz_q   <= z_in_i;
        idx_q  <= seg_index_i;
        dlen_q <= duration_in_i;
        t_q    <= time_in_i;
      end
      S_EXEC: begin
        x_out_o  <= '0;
        y_out_o  <= '0;
        z_out_o  <= '0;
        status_q <= ST_OK;
        wi_q     <= '0;
        beg_q    <= '0;
        if (cmd_q == CMD_APPEND && !can_app) status_q <= st;
        if (cmd_q == CMD_REMOVE && cnt_q == '0) status_q <= st;
        if (cmd_q == CMD_SETDUR && !dur_req.wr_en) status_q <= st;
        if (cmd_q == CMD_EVAL) begin
          if (segs_q == '0) status_q <= ST_IGNORED;
          else if (t_q < 0) status_q <= ST_CLAMPED;
        end
      end
      S_WALK: begin
        if (more) begin
          beg_q <= sum;
          wi_q  <= wi_q + 1'b1;
        end else if (past) begin
          status_q <= ST_CLAMPED;
        end else begin
          base_q <= PT_AW'({wi_q, 1'b0}) + PT_AW'(wi_q);
          f_q    <= FRAC_W'(ONE_Q16);
          pc_q   <= '0;
        end
      end
      S_DIV: begin
        if (div_done) f_q <= {1'b0, div_q};
      end
      S_PRD: begin
        if (pc_q != 3'd0) begin
          ax_q[0][2'(pc_q - 3'd1)] <= pt_rd[95:64];
          ax_q[1][2'(pc_q - 3'd1)] <= pt_rd[63:32];
          ax_q[2][2'(pc_q - 3'd1)] <= pt_rd[31:0];
        end
        pc_q   <= pc_q + 3'd1;
        sub_q  <= '0;
        axis_q <= '0;
      end
      S_LB: begin
        if (sub_q == 3'd5) begin
          x_out_o <= y_out_o;
          y_out_o <= z_out_o;
          z_out_o <= lres;
          ax_q[0] <= ax_q[1];
          ax_q[1] <= ax_q[2];
          sub_q   <= '0;
          axis_q  <= axis_q + 2'd1;
        end else begin
          ax_q[0][asel] <= lres;
          sub_q         <= sub_q + 3'd1;
        end
      end
      S_PT: begin
        x_out_o <= pt_rd[95:64];
        y_out_o <= pt_rd[63:32];
        z_out_o <= pt_rd[31:0];
      end
      default: begin
      end
    endcase
  end

  // checks
  `PCBE_ASSERT(a_cnt_range, cnt_q <= CNT_W'(MAX_POINTS))
  `PCBE_ASSERT(a_done_idle, !(done_o && busy))
  `PCBE_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `PCBE_ASSERT_NEXT(a_div_prd, state_q == S_DIV && div_done, state_q == S_PRD)
endmodule
`default_nettype wire

// ----- sim/pcbe_checker.sv -----
`default_nettype none
module pcbe_checker (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  input  wire                busy,
  input  wire  [1:0]         command_i,
  input  wire  signed [31:0] x_in_i,
  input  wire  signed [31:0] y_in_i,
  input  wire  signed [31:0] z_in_i,
  input  wire  [4:0]         seg_index_i,
  input  wire  [31:0]        duration_in_i,
  input  wire  signed [31:0] time_in_i,
  input  wire                done_o,
  input  wire  signed [31:0] x_out_o,
  input  wire  signed [31:0] y_out_o,
  input  wire  signed [31:0] z_out_o,
  input  wire  [1:0]         status_o,
  input  wire  [6:0]         points_held_o,
  output int                 fail_count,
  output int                 words_pending,
  output int                 evals_ok,
  output int                 evals_clamped
);
  import pcbe_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    status_e            st;
    logic [6:0]         held;
  } curve_word_t;

  // shadow copy of the curve
  logic signed [31:0] px [MAX_POINTS];
  logic signed [31:0] py [MAX_POINTS];
  logic signed [31:0] pz [MAX_POINTS];
  logic [31:0]        seg_dur [MAX_SEGS];
  int                 n_points;
  curve_word_t        curve_expected [$];

  function automatic logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                               logic [16:0] f);
    logic signed [63:0] s;
    s = 64'(a) * $signed({47'd0, 17'd65536 - f}) + 64'(b) * $signed({47'd0, f}) + 64'sd32768;
    return 32'(s >>> 16);
  endfunction

  function automatic logic signed [31:0] bezier3(logic signed [31:0] p0, logic signed [31:0] p1,
                                                 logic signed [31:0] p2, logic signed [31:0] p3,
                                                 logic [16:0] f);
    logic signed [31:0] q0, q1, q2;
    q0 = blend(p0, p1, f);
    q1 = blend(p1, p2, f);
    q2 = blend(p2, p3, f);
    return blend(blend(q0, q1, f), blend(q1, q2, f), f);
  endfunction

  // apply one command word to the shadow curve
  task automatic predict_curve(input cmd_e cmd, input logic signed [31:0] xi, yi, zi,
                               input logic [4:0] idx, input logic [31:0] dur,
                               input logic signed [31:0] t);
    curve_word_t w;
    int segs, sg, b;
    logic [63:0] total, begin_t, off;
    logic [16:0] f;
    w = '0;
    w.st = ST_OK;
    segs = (n_points < 4) ? 0 : (n_points - 1) / 3;
    case (cmd)
      CMD_APPEND: begin
        if (n_points >= MAX_POINTS) begin
          w.st = ST_IGNORED;
        end else begin
          px[n_points] = xi;
          py[n_points] = yi;
          pz[n_points] = zi;
          n_points++;
          if (n_points >= 4 && (n_points - 1) % 3 == 0) seg_dur[(n_points - 1) / 3 - 1] = ONE_Q16;
        end
      end
      CMD_REMOVE: begin
        if (n_points == 0) w.st = ST_IGNORED;
        else n_points--;
      end
      CMD_SETDUR: begin
        if (idx >= segs || dur == 0) w.st = ST_BAD;
        else seg_dur[idx] = dur;
      end
      default: begin
        total = 0;
        for (int i = 0; i < segs; i++) total += seg_dur[i];
        if (segs == 0) begin
          w.st = ST_IGNORED;
          if (n_points > 0) begin
            w.x = px[0]; w.y = py[0]; w.z = pz[0];
          end
        end else if (t < 0) begin
          w.st = ST_CLAMPED;
          w.x = px[0]; w.y = py[0]; w.z = pz[0];
        end else if (64'(t) > total) begin
          w.st = ST_CLAMPED;
          w.x = px[segs * 3]; w.y = py[segs * 3]; w.z = pz[segs * 3];
        end else begin
          begin_t = 0;
          sg = 0;
          while (sg + 1 < segs && 64'(t) > begin_t + seg_dur[sg]) begin
            begin_t += seg_dur[sg];
            sg++;
          end
          off = 64'(t) - begin_t;
          if (off >= seg_dur[sg]) f = 17'd65536;
          else f = 17'((off << 16) / seg_dur[sg]);
          b = sg * 3;
          w.x = bezier3(px[b], px[b+1], px[b+2], px[b+3], f);
          w.y = bezier3(py[b], py[b+1], py[b+2], py[b+3], f);
          w.z = bezier3(pz[b], pz[b+1], pz[b+2], pz[b+3], f);
        end
      end
    endcase
    w.held = 7'(n_points);
    curve_expected = {curve_expected, w};
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
    $display("mismatch %s: got %h expected %h", what, got, exp_v);
    fail_count++;
  endtask

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    curve_word_t e;
    if (!rst_ni) begin
      n_points = 0;
      for (int i = 0; i < MAX_SEGS; i++) seg_dur[i] = ONE_Q16;
      for (int i = 0; i < MAX_POINTS; i++) begin
        px[i] = 0; py[i] = 0; pz[i] = 0;
      end
      curve_expected.delete();
      fail_count = 0;
      evals_ok = 0;
      evals_clamped = 0;
      words_pending = 0;
    end else begin
      if (done_o) begin
        if (curve_expected.size() == 0) begin
          report_mismatch("unexpected word", 32'(status_o), 0);
        end else begin
          e = curve_expected.pop_front();
          if (x_out_o !== e.x) report_mismatch("x", x_out_o, e.x);
          if (y_out_o !== e.y) report_mismatch("y", y_out_o, e.y);
          if (z_out_o !== e.z) report_mismatch("z", z_out_o, e.z);
          if (status_o !== e.st) report_mismatch("status", 32'(status_o), 32'(e.st));
          if (points_held_o !== e.held) report_mismatch("held", 32'(points_held_o), 32'(e.held));
        end
      end
      if (start && !busy) begin
        predict_curve(cmd_e'(command_i), x_in_i, y_in_i, z_in_i, seg_index_i,
                      duration_in_i, time_in_i);
        if (cmd_e'(command_i) == CMD_EVAL) begin
          if (curve_expected[$].st == ST_OK) evals_ok++;
          if (curve_expected[$].st == ST_CLAMPED) evals_clamped++;
        end
      end
      words_pending = curve_expected.size();
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb_piecewise_cubic_bezier_eval_top.sv -----
`default_nettype none
module tb_piecewise_cubic_bezier_eval_top;
  import pcbe_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  wire                busy;
  logic [1:0]         command_i = CMD_APPEND;
  logic signed [31:0] x_in_i = '0;
  logic signed [31:0] y_in_i = '0;
  logic signed [31:0] z_in_i = '0;
  logic [4:0]         seg_index_i = '0;
  logic [31:0]        duration_in_i = '0;
  logic signed [31:0] time_in_i = '0;
  wire                done_o;
  wire signed [31:0]  x_out_o, y_out_o, z_out_o;
  wire [1:0]          status_o;
  wire [6:0]          points_held_o;
  int                 fail_count, words_pending, evals_ok, evals_clamped;
  int                 cycle_count = 0;
  int                 words_sent = 0;
  int                 calm_from, calm_to;
  int                 sim_points = 0;

  piecewise_cubic_bezier_eval_top dut (.*);

  pcbe_checker u_checker (.*);

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // send one command word, with random idling outside the calm stretch
  // start stays high after the word is taken until the next word or an idle
  task automatic send_word(input cmd_e cmd, input logic [31:0] xv, yv, zv,
                           input logic [4:0] idx, input logic [31:0] dur, tv);
    if (!(words_sent >= calm_from && words_sent < calm_to)) begin
      while ($urandom_range(0, 99) < 24) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    start <= 1'b1;
    command_i <= cmd;
    x_in_i <= xv;
    y_in_i <= yv;
    z_in_i <= zv;
    seg_index_i <= idx;
    duration_in_i <= dur;
    time_in_i <= tv;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
    if (cmd == CMD_APPEND && sim_points < MAX_POINTS) sim_points++;
    if (cmd == CMD_REMOVE && sim_points > 0) sim_points--;
  endtask

  // point with moderate x and z coordinates (x now and then an edge value) and a random y
  task automatic append_point();
    send_word(CMD_APPEND, $urandom_range(0, 9) == 0 ? edge_word() : 32'($signed($urandom) >>> 8),
              $urandom, $signed($urandom) >>> 4, $urandom, $urandom, $urandom);
  endtask

  task automatic eval_at(input logic [31:0] tv);
    send_word(CMD_EVAL, $urandom, $urandom, $urandom, $urandom, $urandom, tv);
  endtask

  task automatic random_word();
    int r, segs;
    segs = sim_points < 4 ? 0 : (sim_points - 1) / 3;
    r = $urandom_range(0, 99);
    if (r < 30 && sim_points < MAX_POINTS) append_point();
    else if (r < 38) send_word(CMD_REMOVE, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom);
    else if (r < 50) send_word(CMD_SETDUR, $urandom, $urandom, $urandom,
                               $urandom_range(0, 9) == 0 ? 5'($urandom) :
                               5'($urandom_range(0, segs > 0 ? segs - 1 : 0)),
                               $urandom_range(0, 19) == 0 ? edge_word() :
                               32'($urandom_range(1, 400000)), $urandom);
    else if (r < 90) eval_at(32'($urandom_range(0, (segs + 1) * 140000)));
    else eval_at($urandom_range(0, 1) ? edge_word() : $urandom);
  endtask

  initial begin
    calm_from = 300;
    calm_to = 420;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty store, single point, boundaries, clamps, bad writes
    send_word(CMD_REMOVE, 0, 0, 0, 0, 0, 0);
    eval_at(32'd0);
    send_word(CMD_APPEND, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, 0, 0);
    eval_at(32'd100);
    send_word(CMD_APPEND, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 31, 32'hffff_ffff, 0);
    send_word(CMD_APPEND, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 0, 0, 0);
    send_word(CMD_APPEND, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0);
    eval_at(32'h8000_0000);
    eval_at(32'h7fff_ffff);
    eval_at(32'd0);
    eval_at(32'd65536);
    eval_at(32'd32768);
    send_word(CMD_SETDUR, 0, 0, 0, 5'd1, 32'd100, 0);
    send_word(CMD_SETDUR, 0, 0, 0, 5'd0, 32'd0, 0);
    send_word(CMD_SETDUR, 0, 0, 0, 5'd0, 32'hffff_ffff, 0);
    eval_at(32'h7fff_ffff);
    eval_at(32'd12345);
    repeat (3) append_point();
    send_word(CMD_SETDUR, 0, 0, 0, 5'd1, 32'd3, 0);
    eval_at(32'hffff_0001);
    eval_at(32'hffff_0002);
    eval_at(32'hffff_0004);
    eval_at(32'd65537);

    // fill to capacity then try once more, then drain and rebuild
    while (sim_points < MAX_POINTS) append_point();
    append_point();
    send_word(CMD_SETDUR, 0, 0, 0, 5'd20, 32'd70000, 0);
    eval_at(32'd21 * 65536);
    eval_at(32'd22 * 65536);

    // hold off until every word is back
    start <= 1'b0;
    while (words_pending != 0) @(posedge clk_i);
    @(negedge clk_i);
    while (sim_points > 0)
      send_word(CMD_REMOVE, 0, 0, 0, 0, 0, 0);
    send_word(CMD_REMOVE, 0, 0, 0, 0, 0, 0);

    while (words_sent < 950) random_word();

    start <= 1'b0;
    while (words_pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("sent %0d command words; %0d in-range and %0d clamped evaluations checked",
             words_sent, evals_ok, evals_clamped);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
